// ===== hdl/rbst_pkg.sv =====
`timescale 1ns / 1ps
package rbst_pkg;

    localparam int COORD_W = 32;
    localparam int DIFF_W = COORD_W + 1;
    localparam int FRAC_W = 16;
    localparam int NUM_W = DIFF_W + FRAC_W;
    localparam int DEN_W = COORD_W;
    localparam int REM_W = DEN_W + 1;
    localparam int DIST_W = 48;
    localparam int AXES = 3;
    localparam int LANES = 2 * AXES;
    localparam int DIV_STEPS_PER_STAGE = 2;
    localparam int DIV_STAGES = (NUM_W + DIV_STEPS_PER_STAGE - 1) / DIV_STEPS_PER_STAGE;

    localparam logic signed [DIST_W-1:0] DIST_MAX = {1'b0, {(DIST_W-1){1'b1}}};
    localparam logic signed [DIST_W-1:0] DIST_MIN = {1'b1, {(DIST_W-1){1'b0}}};

    typedef struct packed {
        logic [NUM_W-1:0] nq;
        logic [REM_W-1:0] rem;
        logic [DEN_W-1:0] den;
        logic             neg;
    } div_lane_t;

    typedef struct packed {
        logic [AXES-1:0] par;
        logic            par_miss;
    } side_t;

    typedef struct packed {
        div_lane_t [LANES-1:0] lane;
        side_t                 side;
    } div_word_t;

    // one restoring step: shift in the next numerator bit, subtract if it fits
    function automatic div_lane_t div_step(div_lane_t x);
        div_lane_t        y;
        logic [REM_W-1:0] rem_sh;
        y = x;
        rem_sh = {x.rem[REM_W-2:0], x.nq[NUM_W-1]};
        y.nq = {x.nq[NUM_W-2:0], 1'b0};
        if (rem_sh >= {1'b0, x.den})
        begin
            rem_sh = rem_sh - {1'b0, x.den};
            y.nq[0] = 1'b1;
        end
        y.rem = rem_sh;
        return y;
    endfunction

    function automatic div_word_t div_stage(div_word_t w, int stage);
        div_word_t y;
        y = w;
        for (int j = 0; j < DIV_STEPS_PER_STAGE; j++)
        begin
            if (stage * DIV_STEPS_PER_STAGE + j < NUM_W)
            begin
                for (int l = 0; l < LANES; l++)
                begin
                    y.lane[l] = div_step(y.lane[l]);
                end
            end
        end
        return y;
    endfunction

    function automatic logic signed [DIST_W-1:0] saturate(logic [NUM_W-1:0] m, logic neg);
        logic signed [DIST_W-1:0] r;
        if (!neg)
        begin
            if (m[NUM_W-1:DIST_W-1] != '0)
                r = DIST_MAX;
            else
                r = m[DIST_W-1:0];
        end
        else
        begin
            if (m[NUM_W-1] || (m[DIST_W-1] && (m[DIST_W-2:0] != '0)))
                r = DIST_MIN;
            else
                r = -m[DIST_W-1:0];
        end
        return r;
    endfunction

endpackage

// ===== hdl/rbst_ray_if.sv =====
`timescale 1ns / 1ps
interface rbst_ray_if;
    logic valid;
    logic ready;
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] origin_z;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;
    logic signed [31:0] box_a_x;
    logic signed [31:0] box_a_y;
    logic signed [31:0] box_a_z;
    logic signed [31:0] box_b_x;
    logic signed [31:0] box_b_y;
    logic signed [31:0] box_b_z;

    modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                    box_a_x, box_a_y, box_a_z, box_b_x, box_b_y, box_b_z, input ready);
    modport sink (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                  box_a_x, box_a_y, box_a_z, box_b_x, box_b_y, box_b_z, output ready);
endinterface

// ===== hdl/rbst_hit_if.sv =====
`timescale 1ns / 1ps
interface rbst_hit_if;
    logic valid;
    logic ready;
    logic hit;

    modport source (output valid, hit, input ready);
    modport sink (input valid, hit, output ready);
endinterface

// ===== hdl/rbst_prep.sv =====
`timescale 1ns / 1ps
module rbst_prep
(
    input  logic                 clk,
    input  logic                 rst_n,
    rbst_ray_if.sink             ray_in,
    output logic                 out_valid,
    input  logic                 out_ready,
    output rbst_pkg::div_word_t  out_word
);

    logic                valid_reg;
    logic                en;
    rbst_pkg::div_word_t word_reg;
    rbst_pkg::div_word_t word_next;

    logic signed [rbst_pkg::COORD_W-1:0] o [rbst_pkg::AXES];
    logic signed [rbst_pkg::COORD_W-1:0] d [rbst_pkg::AXES];
    logic signed [rbst_pkg::COORD_W-1:0] a [rbst_pkg::AXES];
    logic signed [rbst_pkg::COORD_W-1:0] b [rbst_pkg::AXES];

    assign o[0] = ray_in.origin_x;
    assign o[1] = ray_in.origin_y;
    assign o[2] = ray_in.origin_z;
    assign d[0] = ray_in.dir_x;
    assign d[1] = ray_in.dir_y;
    assign d[2] = ray_in.dir_z;
    assign a[0] = ray_in.box_a_x;
    assign a[1] = ray_in.box_a_y;
    assign a[2] = ray_in.box_a_z;
    assign b[0] = ray_in.box_b_x;
    assign b[1] = ray_in.box_b_y;
    assign b[2] = ray_in.box_b_z;

    assign en = !valid_reg || out_ready;
    assign ray_in.ready = en;
    assign out_valid = valid_reg;
    assign out_word = word_reg;

    always_comb
    begin
        logic signed [rbst_pkg::DIFF_W-1:0] diff;
        logic [rbst_pkg::DIFF_W-1:0]        mag;
        logic [rbst_pkg::DEN_W-1:0]         den;
        logic signed [rbst_pkg::COORD_W-1:0] lo;
        logic signed [rbst_pkg::COORD_W-1:0] hi;
        word_next = '0;
        for (int ax = 0; ax < rbst_pkg::AXES; ax++)
        begin
            den = d[ax][rbst_pkg::COORD_W-1] ? -d[ax] : d[ax];
            for (int k = 0; k < 2; k++)
            begin
                diff = (k == 0) ? ({a[ax][rbst_pkg::COORD_W-1], a[ax]} -
                                   {o[ax][rbst_pkg::COORD_W-1], o[ax]})
                                : ({b[ax][rbst_pkg::COORD_W-1], b[ax]} -
                                   {o[ax][rbst_pkg::COORD_W-1], o[ax]});
                mag = diff[rbst_pkg::DIFF_W-1] ? -diff : diff;
                word_next.lane[2*ax+k].nq = {mag, {rbst_pkg::FRAC_W{1'b0}}};
                word_next.lane[2*ax+k].rem = '0;
                word_next.lane[2*ax+k].den = den;
                word_next.lane[2*ax+k].neg = diff[rbst_pkg::DIFF_W-1] ^
                                             d[ax][rbst_pkg::COORD_W-1];
            end
            lo = (a[ax] < b[ax]) ? a[ax] : b[ax];
            hi = (a[ax] < b[ax]) ? b[ax] : a[ax];
            word_next.side.par[ax] = (d[ax] == '0);
            if ((d[ax] == '0) && ((o[ax] < lo) || (o[ax] > hi)))
                word_next.side.par_miss = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= ray_in.valid;
    end

    always_ff @(posedge clk)
    begin
        if (en && ray_in.valid)
            word_reg <= word_next;
    end

endmodule

// ===== hdl/rbst_div.sv =====
`timescale 1ns / 1ps
module rbst_div
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  rbst_pkg::div_word_t  in_word,
    output logic                 out_valid,
    input  logic                 out_ready,
    output rbst_pkg::div_word_t  out_word
);

    localparam int N = rbst_pkg::DIV_STAGES;

    logic [N-1:0]        valid_reg;
    logic [N-1:0]        en;
    rbst_pkg::div_word_t stage_reg  [N];
    rbst_pkg::div_word_t stage_next [N];

    genvar s;
    generate
        for (s = 0; s < N; s++)
        begin : g_stage
            if (s == N - 1)
            begin : g_last
                assign en[s] = !valid_reg[s] || out_ready;
            end
            else
            begin : g_mid
                assign en[s] = !valid_reg[s] || en[s+1];
            end

            if (s == 0)
            begin : g_first
                assign stage_next[s] = rbst_pkg::div_stage(in_word, s);
                always_ff @(posedge clk or negedge rst_n)
                begin
                    if (!rst_n)
                        valid_reg[s] <= 1'b0;
                    else if (en[s])
                        valid_reg[s] <= in_valid;
                end
                always_ff @(posedge clk)
                begin
                    if (en[s] && in_valid)
                        stage_reg[s] <= stage_next[s];
                end
            end
            else
            begin : g_rest
                assign stage_next[s] = rbst_pkg::div_stage(stage_reg[s-1], s);
                always_ff @(posedge clk or negedge rst_n)
                begin
                    if (!rst_n)
                        valid_reg[s] <= 1'b0;
                    else if (en[s])
                        valid_reg[s] <= valid_reg[s-1];
                end
                always_ff @(posedge clk)
                begin
                    if (en[s] && valid_reg[s-1])
                        stage_reg[s] <= stage_next[s];
                end
            end
        end
    endgenerate

    assign in_ready = en[0];
    assign out_valid = valid_reg[N-1];
    assign out_word = stage_reg[N-1];

endmodule

// ===== hdl/rbst_reduce.sv =====
`timescale 1ns / 1ps
module rbst_reduce
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  rbst_pkg::div_word_t  in_word,
    rbst_hit_if.source           hit_out
);

    typedef logic signed [rbst_pkg::DIST_W-1:0] dist_t;

    // stage A: per-axis near and far distances
    logic            a_valid_reg;
    logic            a_en;
    dist_t           tlo_reg  [rbst_pkg::AXES];
    dist_t           thi_reg  [rbst_pkg::AXES];
    dist_t           tlo_next [rbst_pkg::AXES];
    dist_t           thi_next [rbst_pkg::AXES];
    rbst_pkg::side_t a_side_reg;

    // stage B: entry and exit
    logic  b_valid_reg;
    logic  b_en;
    dist_t entry_reg;
    dist_t exit_reg;
    dist_t entry_next;
    dist_t exit_next;
    logic  b_miss_reg;

    // stage C: result
    logic c_valid_reg;
    logic c_en;
    logic hit_reg;

    assign c_en = !c_valid_reg || hit_out.ready;
    assign b_en = !b_valid_reg || c_en;
    assign a_en = !a_valid_reg || b_en;
    assign in_ready = a_en;

    always_comb
    begin
        dist_t ta;
        dist_t tb;
        for (int ax = 0; ax < rbst_pkg::AXES; ax++)
        begin
            ta = rbst_pkg::saturate(in_word.lane[2*ax].nq, in_word.lane[2*ax].neg);
            tb = rbst_pkg::saturate(in_word.lane[2*ax+1].nq, in_word.lane[2*ax+1].neg);
            tlo_next[ax] = (ta < tb) ? ta : tb;
            thi_next[ax] = (ta < tb) ? tb : ta;
        end
    end

    always_comb
    begin
        entry_next = rbst_pkg::DIST_MIN;
        exit_next = rbst_pkg::DIST_MAX;
        // parallel axes constrain nothing
        for (int ax = 0; ax < rbst_pkg::AXES; ax++)
        begin
            if (!a_side_reg.par[ax])
            begin
                if (tlo_reg[ax] > entry_next)
                    entry_next = tlo_reg[ax];
                if (thi_reg[ax] < exit_next)
                    exit_next = thi_reg[ax];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_en)
                a_valid_reg <= in_valid;
            if (b_en)
                b_valid_reg <= a_valid_reg;
            if (c_en)
                c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_en && in_valid)
        begin
            tlo_reg <= tlo_next;
            thi_reg <= thi_next;
            a_side_reg <= in_word.side;
        end
        if (b_en && a_valid_reg)
        begin
            entry_reg <= entry_next;
            exit_reg <= exit_next;
            b_miss_reg <= a_side_reg.par_miss;
        end
        if (c_en && b_valid_reg)
            hit_reg <= !(b_miss_reg || (exit_reg < 0) || (entry_reg > exit_reg));
    end

    assign hit_out.valid = c_valid_reg;
    assign hit_out.hit = hit_reg;

endmodule

// ===== hdl/ray_box_slab_test.sv =====
`timescale 1ns / 1ps
// channel   modport  item
// ray_in    sink     origin, direction and two box corners, 12 x Q16.16
// hit_out   source   hit flag, one per ray
//
// One item enters per cycle while hit_out does not stall; the result leaves after
// 1 setup stage, 25 divider stages at up to two quotient bits each and 3 reduce stages.
// The 49-bit restoring divider pipeline sets the latency.
// rst_n clears every valid bit at once; payload registers are not reset.
// A stall on hit_out holds each full stage; empty stages still fill.
module ray_box_slab_test
(
    input  logic       clk,
    input  logic       rst_n,
    rbst_ray_if.sink   ray_in,
    rbst_hit_if.source hit_out
);

    logic                p_valid;
    logic                p_ready;
    rbst_pkg::div_word_t p_word;
    logic                d_valid;
    logic                d_ready;
    rbst_pkg::div_word_t d_word;

    rbst_prep u_prep
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .ray_in    (ray_in),
        .out_valid (p_valid),
        .out_ready (p_ready),
        .out_word  (p_word)
    );

    rbst_div u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (p_valid),
        .in_ready  (p_ready),
        .in_word   (p_word),
        .out_valid (d_valid),
        .out_ready (d_ready),
        .out_word  (d_word)
    );

    rbst_reduce u_reduce
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (d_valid),
        .in_ready (d_ready),
        .in_word  (d_word),
        .hit_out  (hit_out)
    );

endmodule
